### design/sqg_pkg.sv
// Shared constants, tables and types of the UV-sphere quad generator.
`default_nettype none

package sqg_pkg;

   localparam int MAX_SEGMENTS = 1024;
   localparam int PHASE_BITS   = 16;
   localparam int TRIG_BITS    = 16;

   localparam int IDX_W      = 10;
   localparam int SEG_W      = 11;
   localparam int COORD_W    = 32;
   localparam int RADIUS_W   = 31;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam int DEN_W     = SEG_W + 1;
   localparam int REM_W     = SEG_W;
   localparam int NUM_W     = SEG_W + PHASE_BITS + 1;
   localparam int DIV_STEPS = NUM_W;

   localparam int ANGLE_W      = 32;
   localparam int CORDIC_STEPS = 24;
   localparam int CORDIC_FRAC  = 30;
   localparam int TRIG_W       = TRIG_BITS + 2;
   localparam logic signed [ANGLE_W-1:0] CORDIC_X0 = 32'sd652032874;

   localparam logic [PHASE_BITS-1:0] LAT_OFFSET = PHASE_BITS'(1 << (PHASE_BITS - 2));

   localparam logic signed [ANGLE_W-1:0] ATAN_TABLE [CORDIC_STEPS] = '{
      32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004757,
      32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
      32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
      32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
      32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
      32'sd652,       32'sd326,       32'sd163,       32'sd81
   };

   localparam int DIV_LAT    = DIV_STEPS;
   localparam int CORDIC_LAT = CORDIC_STEPS + 3;
   localparam int VERTEX_LAT = 4;
   localparam int PIPE_LAT   = DIV_LAT + CORDIC_LAT + VERTEX_LAT;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CENTER_X      = 3'd0,
      CSR_CENTER_Y      = 3'd1,
      CSR_CENTER_Z      = 3'd2,
      CSR_SPHERE_RADIUS = 3'd3,
      CSR_SEGMENT_COUNT = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0] cs;
      logic signed [TRIG_W-1:0] sn;
   } trig_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } vec_type;

   typedef struct packed {
      vec_type v0;
      vec_type v1;
      vec_type v2;
      vec_type v3;
   } quad_type;

endpackage

`default_nettype wire

### design/sqg_phase_div.sv
// Pipelined restoring divider that yields the low phase bits of a quotient.
`default_nettype none

module sqg_phase_div (
   input  wire logic                            clock,
   input  wire logic                            en,
   input  wire logic [sqg_pkg::NUM_W-1:0]       dividend,
   input  wire logic [sqg_pkg::DEN_W-1:0]       divisor,
   output logic      [sqg_pkg::PHASE_BITS-1:0]  quotient
);

   localparam int STEPS = sqg_pkg::DIV_STEPS;
   localparam int NW    = sqg_pkg::NUM_W;
   localparam int RW    = sqg_pkg::REM_W;
   localparam int PB    = sqg_pkg::PHASE_BITS;

   logic [NW-1:0] num_src [STEPS];
   logic [RW-1:0] rem_src [STEPS];
   logic [PB-1:0] quo_src [STEPS+1];

   assign num_src[0] = dividend;
   assign rem_src[0] = '0;
   assign quo_src[0] = '0;

   for (genvar s = 0; s < STEPS; s++) begin : g_step
      logic [RW:0]   trial;
      logic [RW:0]   diff;
      logic          ge;
      logic [RW-1:0] rem_in;
      logic [PB-1:0] quo_in;
      logic [PB-1:0] quo_ff;

      assign trial  = {rem_src[s], num_src[s][NW-1]};
      assign ge     = trial >= divisor;
      assign diff   = trial - divisor;
      assign rem_in = ge ? diff[RW-1:0] : trial[RW-1:0];
      assign quo_in = {quo_src[s][PB-2:0], ge};

      always_ff @(posedge clock) begin
         if (en) begin
            quo_ff <= quo_in;
         end
      end
      assign quo_src[s+1] = quo_ff;

      if (s < STEPS - 1) begin : g_carry
         logic [RW-1:0] rem_ff;
         logic [NW-1:0] num_ff;
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff <= rem_in;
               num_ff <= {num_src[s][NW-2:0], 1'b0};
            end
         end
         assign rem_src[s+1] = rem_ff;
         assign num_src[s+1] = num_ff;
      end
   end

   assign quotient = quo_src[STEPS];

endmodule

`default_nettype wire

### design/sqg_cordic.sv
// Pipelined rotation CORDIC giving cosine and sine of a phase.
`default_nettype none

module sqg_cordic (
   input  wire logic                            clock,
   input  wire logic                            en,
   input  wire logic [sqg_pkg::PHASE_BITS-1:0]  phase,
   output sqg_pkg::trig_type                    trig
);

   localparam int STEPS = sqg_pkg::CORDIC_STEPS;
   localparam int AW    = sqg_pkg::ANGLE_W;
   localparam int PB    = sqg_pkg::PHASE_BITS;
   localparam int TW    = sqg_pkg::TRIG_W;
   localparam int RSH   = sqg_pkg::CORDIC_FRAC - sqg_pkg::TRIG_BITS;
   localparam logic signed [AW+1:0] HALF     = (AW+2)'(1) <<< (RSH - 1);
   localparam logic signed [AW+1:0] ONE_POS  = (AW+2)'(1) <<< sqg_pkg::TRIG_BITS;
   localparam logic signed [AW+1:0] ONE_NEG  = -ONE_POS;

   logic [AW-1:0]        angle;
   logic [1:0]           quad_in;
   logic signed [AW-1:0] z_in;

   logic signed [AW-1:0] x_src [STEPS+1];
   logic signed [AW-1:0] y_src [STEPS+1];
   logic signed [AW-1:0] z_src [STEPS];
   logic [1:0]           q_src [STEPS+1];

   logic signed [AW-1:0] x0_ff, z0_ff;
   logic [1:0]           q0_ff;

   assign angle   = {phase, (AW-PB)'(0)};
   assign quad_in = angle[AW-1:AW-2] + {1'b0, angle[AW-3]};
   assign z_in    = AW'($signed(angle[AW-3:0]));

   always_ff @(posedge clock) begin
      if (en) begin
         x0_ff <= sqg_pkg::CORDIC_X0;
         z0_ff <= z_in;
         q0_ff <= quad_in;
      end
   end

   assign x_src[0] = x0_ff;
   assign y_src[0] = '0;
   assign z_src[0] = z0_ff;
   assign q_src[0] = q0_ff;

   for (genvar k = 0; k < STEPS; k++) begin : g_iter
      logic signed [AW-1:0] dx, dy, x_in, y_in, x_ff, y_ff;
      logic [1:0]           q_ff;
      logic                 up;

      assign dx   = y_src[k] >>> k;
      assign dy   = x_src[k] >>> k;
      assign up   = !z_src[k][AW-1];
      assign x_in = up ? x_src[k] - dx : x_src[k] + dx;
      assign y_in = up ? y_src[k] + dy : y_src[k] - dy;

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff <= x_in;
            y_ff <= y_in;
            q_ff <= q_src[k];
         end
      end
      assign x_src[k+1] = x_ff;
      assign y_src[k+1] = y_ff;
      assign q_src[k+1] = q_ff;

      if (k < STEPS - 1) begin : g_angle
         logic signed [AW-1:0] z_ff;
         always_ff @(posedge clock) begin
            if (en) begin
               z_ff <= up ? z_src[k] - sqg_pkg::ATAN_TABLE[k]
                          : z_src[k] + sqg_pkg::ATAN_TABLE[k];
            end
         end
         assign z_src[k+1] = z_ff;
      end
   end

   logic signed [AW:0] xe, ye, c_in, s_in, c_ff, s_ff;

   assign xe = (AW+1)'(x_src[STEPS]);
   assign ye = (AW+1)'(y_src[STEPS]);

   always_comb begin
      case (q_src[STEPS])
         2'd0: begin
            c_in = xe;
            s_in = ye;
         end
         2'd1: begin
            c_in = -ye;
            s_in = xe;
         end
         2'd2: begin
            c_in = -xe;
            s_in = -ye;
         end
         default: begin
            c_in = ye;
            s_in = -xe;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_ff <= c_in;
         s_ff <= s_in;
      end
   end

   function automatic logic signed [TW-1:0] round_clamp(input logic signed [AW:0] v);
      logic signed [AW+1:0] sum;
      logic signed [AW+1:0] sh;
      sum = (AW+2)'(v) + HALF;
      sh  = sum >>> RSH;
      if (sh > ONE_POS) begin
         round_clamp = TW'(ONE_POS);
      end else if (sh < ONE_NEG) begin
         round_clamp = TW'(ONE_NEG);
      end else begin
         round_clamp = sh[TW-1:0];
      end
   endfunction

   sqg_pkg::trig_type trig_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         trig_ff.cs <= round_clamp(c_ff);
         trig_ff.sn <= round_clamp(s_ff);
      end
   end

   assign trig = trig_ff;

endmodule

`default_nettype wire

### design/sqg_vertex.sv
// Vertex stage: direction products, radius scaling and center offset.
`default_nettype none

module sqg_vertex (
   input  wire logic                             clock,
   input  wire logic                             en,
   input  wire sqg_pkg::trig_type                lat,
   input  wire sqg_pkg::trig_type                lng,
   input  wire logic [sqg_pkg::RADIUS_W-1:0]     radius,
   input  wire sqg_pkg::vec_type                 center,
   output sqg_pkg::vec_type                      vertex
);

   localparam int TW = sqg_pkg::TRIG_W;
   localparam int TB = sqg_pkg::TRIG_BITS;
   localparam int CW = sqg_pkg::COORD_W;
   localparam int PW = 2 * TW;
   localparam int MW = CW + TW;
   localparam int SW = MW - TB + 1;
   localparam logic signed [PW:0]   P_HALF = (PW+1)'(1) <<< (TB - 1);
   localparam logic signed [MW:0]   M_HALF = (MW+1)'(1) <<< (TB - 1);
   localparam logic signed [SW:0]   S_MAX  = (SW+1)'((64'sd1 <<< (CW - 1)) - 64'sd1);
   localparam logic signed [SW:0]   S_MIN  = -((SW+1)'(1) <<< (CW - 1));

   logic signed [PW-1:0] px_ff, py_ff;
   logic signed [TW-1:0] sl1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff  <= lat.cs * lng.cs;
         py_ff  <= lat.cs * lng.sn;
         sl1_ff <= lat.sn;
      end
   end

   logic signed [PW:0]   px_sum, py_sum;
   logic signed [TW-1:0] fx_ff, fy_ff, fz_ff;

   assign px_sum = (PW+1)'(px_ff) + P_HALF;
   assign py_sum = (PW+1)'(py_ff) + P_HALF;

   always_ff @(posedge clock) begin
      if (en) begin
         fx_ff <= px_sum[TB+TW-1:TB];
         fy_ff <= py_sum[TB+TW-1:TB];
         fz_ff <= sl1_ff;
      end
   end

   logic signed [CW-1:0] rad_s;
   logic signed [MW-1:0] mx_ff, my_ff, mz_ff;

   assign rad_s = $signed({1'b0, radius});

   always_ff @(posedge clock) begin
      if (en) begin
         mx_ff <= rad_s * fx_ff;
         my_ff <= rad_s * fy_ff;
         mz_ff <= rad_s * fz_ff;
      end
   end

   function automatic logic signed [CW-1:0] place(input logic signed [MW-1:0] m,
                                                   input logic signed [CW-1:0] c);
      logic signed [MW:0] sum;
      logic signed [SW:0] total;
      sum   = (MW+1)'(m) + M_HALF;
      total = (SW+1)'($signed(sum[MW:TB])) + (SW+1)'(c);
      if (total > S_MAX) begin
         place = S_MAX[CW-1:0];
      end else if (total < S_MIN) begin
         place = S_MIN[CW-1:0];
      end else begin
         place = total[CW-1:0];
      end
   endfunction

   sqg_pkg::vec_type vertex_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         vertex_ff.x <= place(mx_ff, center.x);
         vertex_ff.y <= place(my_ff, center.y);
         vertex_ff.z <= place(mz_ff, center.z);
      end
   end

   assign vertex = vertex_ff;

endmodule

`default_nettype wire

### design/uv_sphere_quad_generator_unit.sv
// Top level of the UV-sphere quad generator: registers, pipeline and output buffer.
//
// Takes one quad request (ring, slice) per cycle while req_ready is high and
// returns the quad's four corners as signed Q16.16 coordinates. The pipeline
// is 59 stages deep (a 28-stage phase divider resolving one quotient bit per
// stage, a 27-stage CORDIC and a 4-stage multiply/offset unit), followed by
// the output register that drives the rsp_ side. One item enters in every cycle
// the pipeline advances; the pipeline halts only when both the output register
// and its skid entry hold items, so the sustained rate is one item per cycle
// while results are taken. Configuration registers are written with csr_wr_en and
// must be changed only while no item is in flight.
`default_nettype none

module uv_sphere_quad_generator_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wr_en,
   input  wire logic [sqg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [sqg_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [sqg_pkg::IDX_W-1:0]         req_ring_index,
   input  wire logic [sqg_pkg::IDX_W-1:0]         req_slice_index,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic signed [sqg_pkg::COORD_W-1:0]     rsp_v0_x,
   output logic signed [sqg_pkg::COORD_W-1:0]     rsp_v0_y,
   output logic signed [sqg_pkg::COORD_W-1:0]     rsp_v0_z,
   output logic signed [sqg_pkg::COORD_W-1:0]     rsp_v1_x,
   output logic signed [sqg_pkg::COORD_W-1:0]     rsp_v1_y,
   output logic signed [sqg_pkg::COORD_W-1:0]     rsp_v1_z,
   output logic signed [sqg_pkg::COORD_W-1:0]     rsp_v2_x,
   output logic signed [sqg_pkg::COORD_W-1:0]     rsp_v2_y,
   output logic signed [sqg_pkg::COORD_W-1:0]     rsp_v2_z,
   output logic signed [sqg_pkg::COORD_W-1:0]     rsp_v3_x,
   output logic signed [sqg_pkg::COORD_W-1:0]     rsp_v3_y,
   output logic signed [sqg_pkg::COORD_W-1:0]     rsp_v3_z
);

   localparam int LAT  = sqg_pkg::PIPE_LAT;
   localparam int SW   = sqg_pkg::SEG_W;
   localparam int NW   = sqg_pkg::NUM_W;
   localparam int PB   = sqg_pkg::PHASE_BITS;
   localparam int RW   = sqg_pkg::RADIUS_W;
   localparam logic [SW-1:0] SEG_MAX = SW'(sqg_pkg::MAX_SEGMENTS);

   sqg_pkg::vec_type    center_ff;
   logic [RW-1:0]       radius_ff;
   logic [SW-1:0]       seg_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff    <= '0;
         radius_ff    <= RW'(65536);
         seg_count_ff <= SW'(16);
      end else if (csr_wr_en) begin
         case (sqg_pkg::csr_index_type'(csr_index))
            sqg_pkg::CSR_CENTER_X:      center_ff.x  <= csr_wdata;
            sqg_pkg::CSR_CENTER_Y:      center_ff.y  <= csr_wdata;
            sqg_pkg::CSR_CENTER_Z:      center_ff.z  <= csr_wdata;
            sqg_pkg::CSR_SPHERE_RADIUS: radius_ff    <= csr_wdata[RW-1:0];
            sqg_pkg::CSR_SEGMENT_COUNT: seg_count_ff <= csr_wdata[SW-1:0];
            default: ;
         endcase
      end
   end

   logic [SW-1:0]               n_eff;
   logic [sqg_pkg::DEN_W-1:0]   divisor;

   always_comb begin
      if (seg_count_ff == '0) begin
         n_eff = SW'(1);
      end else if (seg_count_ff > SEG_MAX) begin
         n_eff = SEG_MAX;
      end else begin
         n_eff = seg_count_ff;
      end
   end
   assign divisor = {n_eff, 1'b0};

   logic en;
   logic skid_valid_ff;

   assign en        = !skid_valid_ff;
   assign req_ready = en;

   logic [SW-1:0] ring0, ring1, slice0, slice1;
   logic [NW-1:0] lat_num0, lat_num1, lng_num0, lng_num1;
   logic          lower_half;

   assign ring0  = SW'(req_ring_index);
   assign ring1  = ring0 + SW'(1);
   assign slice0 = SW'(req_slice_index);
   assign slice1 = slice0 + SW'(1);

   assign lat_num0 = NW'({ring0, PB'(0)}) + NW'(n_eff);
   assign lat_num1 = NW'({ring1, PB'(0)}) + NW'(n_eff);
   assign lng_num0 = {slice0, (PB+1)'(0)} + NW'(n_eff);
   assign lng_num1 = {slice1, (PB+1)'(0)} + NW'(n_eff);

   assign lower_half = req_ring_index < n_eff[SW-1:1];

   logic [PB-1:0] lat_q0, lat_q1, lng_q0, lng_q1;

   sqg_phase_div u_div_lat0 (.clock, .en, .dividend(lat_num0), .divisor, .quotient(lat_q0));
   sqg_phase_div u_div_lat1 (.clock, .en, .dividend(lat_num1), .divisor, .quotient(lat_q1));
   sqg_phase_div u_div_lng0 (.clock, .en, .dividend(lng_num0), .divisor, .quotient(lng_q0));
   sqg_phase_div u_div_lng1 (.clock, .en, .dividend(lng_num1), .divisor, .quotient(lng_q1));

   logic [PB-1:0] lat_ph0, lat_ph1;

   assign lat_ph0 = lat_q0 - sqg_pkg::LAT_OFFSET;
   assign lat_ph1 = lat_q1 - sqg_pkg::LAT_OFFSET;

   sqg_pkg::trig_type lat_t0, lat_t1, lng_t0, lng_t1;

   sqg_cordic u_trig_lat0 (.clock, .en, .phase(lat_ph0), .trig(lat_t0));
   sqg_cordic u_trig_lat1 (.clock, .en, .phase(lat_ph1), .trig(lat_t1));
   sqg_cordic u_trig_lng0 (.clock, .en, .phase(lng_q0),  .trig(lng_t0));
   sqg_cordic u_trig_lng1 (.clock, .en, .phase(lng_q1),  .trig(lng_t1));

   sqg_pkg::vec_type va, vb, vc, vd;

   sqg_vertex u_vert_a (.clock, .en, .lat(lat_t0), .lng(lng_t0), .radius(radius_ff),
                        .center(center_ff), .vertex(va));
   sqg_vertex u_vert_b (.clock, .en, .lat(lat_t1), .lng(lng_t0), .radius(radius_ff),
                        .center(center_ff), .vertex(vb));
   sqg_vertex u_vert_c (.clock, .en, .lat(lat_t1), .lng(lng_t1), .radius(radius_ff),
                        .center(center_ff), .vertex(vc));
   sqg_vertex u_vert_d (.clock, .en, .lat(lat_t0), .lng(lng_t1), .radius(radius_ff),
                        .center(center_ff), .vertex(vd));

   logic valid_ff [LAT];
   logic lower_ff [LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LAT; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (en) begin
         valid_ff[0] <= req_valid;
         for (int k = 1; k < LAT; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lower_ff[0] <= lower_half;
         for (int k = 1; k < LAT; k++) begin
            lower_ff[k] <= lower_ff[k-1];
         end
      end
   end

   sqg_pkg::quad_type quad_in;

   always_comb begin
      if (lower_ff[LAT-1]) begin
         quad_in.v0 = vb;
         quad_in.v1 = vd;
         quad_in.v2 = va;
         quad_in.v3 = vc;
      end else begin
         quad_in.v0 = vc;
         quad_in.v1 = va;
         quad_in.v2 = vb;
         quad_in.v3 = vd;
      end
   end

   sqg_pkg::quad_type out_ff, skid_ff;
   logic              out_valid_ff;
   logic              push, pop;

   assign push = en && valid_ff[LAT-1];
   assign pop  = out_valid_ff && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (out_valid_ff && !pop) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_ff <= skid_ff;
         end
      end else if (push) begin
         if (out_valid_ff && !pop) begin
            skid_ff <= quad_in;
         end else begin
            out_ff <= quad_in;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_v0_x  = out_ff.v0.x;
   assign rsp_v0_y  = out_ff.v0.y;
   assign rsp_v0_z  = out_ff.v0.z;
   assign rsp_v1_x  = out_ff.v1.x;
   assign rsp_v1_y  = out_ff.v1.y;
   assign rsp_v1_z  = out_ff.v1.z;
   assign rsp_v2_x  = out_ff.v2.x;
   assign rsp_v2_y  = out_ff.v2.y;
   assign rsp_v2_z  = out_ff.v2.z;
   assign rsp_v3_x  = out_ff.v3.x;
   assign rsp_v3_y  = out_ff.v3.y;
   assign rsp_v3_z  = out_ff.v3.z;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without an output item");

   a_blocked_push_to_skid: assert property (@(posedge clock) disable iff (reset)
      (push && out_valid_ff && !rsp_ready) |=> skid_valid_ff)
      else $error("item from pipeline not captured in skid entry");

   a_skid_fill_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && !rsp_ready && valid_ff[LAT-1]))
      else $error("skid entry filled without a stalled output");

   a_drain_skid: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && rsp_ready) |=> (out_valid_ff && !skid_valid_ff))
      else $error("skid entry not moved to output");

endmodule

`default_nettype wire

### verif/testbench.sv
// Self-checking testbench for the quad generator with a local vertex predictor.
`default_nettype none

module testbench;

   typedef struct {
      logic [sqg_pkg::IDX_W-1:0] ring;
      logic [sqg_pkg::IDX_W-1:0] slice;
   } quad_req_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_wr_en = 0;
   logic [sqg_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [sqg_pkg::CSR_DATA_W-1:0] csr_wdata = '0;
   logic req_valid = 0;
   logic req_ready;
   logic [sqg_pkg::IDX_W-1:0] req_ring_index = '0;
   logic [sqg_pkg::IDX_W-1:0] req_slice_index = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [sqg_pkg::COORD_W-1:0] rsp_v0_x, rsp_v0_y, rsp_v0_z;
   logic signed [sqg_pkg::COORD_W-1:0] rsp_v1_x, rsp_v1_y, rsp_v1_z;
   logic signed [sqg_pkg::COORD_W-1:0] rsp_v2_x, rsp_v2_y, rsp_v2_z;
   logic signed [sqg_pkg::COORD_W-1:0] rsp_v3_x, rsp_v3_y, rsp_v3_z;

   uv_sphere_quad_generator_unit i_dut (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   quad_req_type pending_reqs[$];
   sqg_pkg::quad_type expected_quads[$];
   longint sph_cx = 0, sph_cy = 0, sph_cz = 0, sph_radius = 65536, sph_segments = 16;
   int errors = 0;
   int accepted = 0;
   int cycles = 0;
   int idle_mode = 0;
   int hold_left = 0;
   bit held_once = 0;
   bit taken = 0;

   localparam longint ARCTAN_TURNS [24] = '{
      536870912, 316933406, 167458907, 85004757, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81};

   function automatic longint rnd_shift(longint v, int k);
      return (v + (longint'(1) << (k - 1))) >>> k;
   endfunction

   function automatic longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint clip_unit(longint v);
      if (v > 65536) return 65536;
      if (v < -65536) return -65536;
      return v;
   endfunction

   function automatic void phase_trig(input logic [15:0] ph, output longint cs,
                                      output longint sn);
      logic [31:0] a, q, r;
      longint x, y, z, dx, dy, c, s;
      a = {ph, 16'h0};
      q = ((a + 32'h2000_0000) >> 30) & 32'd3;
      r = a - (q << 30);
      z = longint'($signed(r));
      x = 652032874;
      y = 0;
      for (int k = 0; k < 24; k++) begin
         dx = y >>> k;
         dy = x >>> k;
         if (z >= 0) begin
            x = x - dx; y = y + dy; z = z - ARCTAN_TURNS[k];
         end else begin
            x = x + dx; y = y - dy; z = z + ARCTAN_TURNS[k];
         end
      end
      case (q)
         0: begin c = x; s = y; end
         1: begin c = -y; s = x; end
         2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
      cs = clip_unit(rnd_shift(c, 14));
      sn = clip_unit(rnd_shift(s, 14));
   endfunction

   function automatic longint grid_size();
      if (sph_segments == 0) return 1;
      if (sph_segments > sqg_pkg::MAX_SEGMENTS) return sqg_pkg::MAX_SEGMENTS;
      return sph_segments;
   endfunction

   function automatic sqg_pkg::vec_type grid_vertex(longint i, longint j, longint n);
      longint lng, lat, cl, sl, cn, sn, fx, fy;
      sqg_pkg::vec_type p;
      lng = ((j << 17) + n) / (2 * n);
      lat = ((i << 16) + n) / (2 * n);
      lat = (lat - 16384) & 64'hFFFF;
      phase_trig(lat[15:0], cl, sl);
      phase_trig(lng[15:0], cn, sn);
      fx = rnd_shift(cl * cn, 16);
      fy = rnd_shift(cl * sn, 16);
      p.x = 32'(clip32(rnd_shift(sph_radius * fx, 16) + sph_cx));
      p.y = 32'(clip32(rnd_shift(sph_radius * fy, 16) + sph_cy));
      p.z = 32'(clip32(rnd_shift(sph_radius * sl, 16) + sph_cz));
      return p;
   endfunction

   function automatic sqg_pkg::quad_type quad_corners(quad_req_type r);
      longint n, i, j;
      sqg_pkg::vec_type va, vb, vc, vd;
      sqg_pkg::quad_type qd;
      n = grid_size();
      i = r.ring;
      j = r.slice;
      va = grid_vertex(i, j, n);
      vb = grid_vertex(i + 1, j, n);
      vc = grid_vertex(i + 1, j + 1, n);
      vd = grid_vertex(i, j + 1, n);
      if (i < n / 2) qd = '{vb, vd, va, vc};
      else qd = '{vc, va, vb, vd};
      return qd;
   endfunction

   task automatic write_reg(sqg_pkg::csr_index_type idx, logic [31:0] val);
      @(negedge clock);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         sqg_pkg::CSR_CENTER_X: sph_cx = longint'($signed(val));
         sqg_pkg::CSR_CENTER_Y: sph_cy = longint'($signed(val));
         sqg_pkg::CSR_CENTER_Z: sph_cz = longint'($signed(val));
         sqg_pkg::CSR_SPHERE_RADIUS: sph_radius = longint'(val[30:0]);
         sqg_pkg::CSR_SEGMENT_COUNT: sph_segments = longint'(val[10:0]);
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 0;
   endtask

   task automatic set_sphere(logic [31:0] cx, cy, cz, rad, segs);
      write_reg(sqg_pkg::CSR_CENTER_X, cx);
      write_reg(sqg_pkg::CSR_CENTER_Y, cy);
      write_reg(sqg_pkg::CSR_CENTER_Z, cz);
      write_reg(sqg_pkg::CSR_SPHERE_RADIUS, rad);
      write_reg(sqg_pkg::CSR_SEGMENT_COUNT, segs);
   endtask

   task automatic queue_quad(int ring, int slice);
      quad_req_type r;
      r.ring = sqg_pkg::IDX_W'(ring);
      r.slice = sqg_pkg::IDX_W'(slice);
      pending_reqs.insert(pending_reqs.size(), r);
   endtask

   task automatic queue_random(int count);
      int n;
      n = int'(grid_size());
      repeat (count) begin
         if ($urandom_range(9) == 0) queue_quad($urandom_range(1023), $urandom_range(1023));
         else queue_quad($urandom_range(n - 1), $urandom_range(n - 1));
      end
   endtask

   task automatic drain();
      wait (pending_reqs.size() == 0 && expected_quads.size() == 0);
      repeat (sqg_pkg::PIPE_LAT + 10) @(negedge clock);
   endtask

   // driver
   always @(negedge clock) begin
      if (req_valid && !taken) begin
      end else if (pending_reqs.size() > 0 &&
                   $urandom_range(99) >= (idle_mode == 0 ? 26 : idle_mode == 1 ? 55 : 0)) begin
         req_valid <= 1;
         req_ring_index <= pending_reqs[0].ring;
         req_slice_index <= pending_reqs[0].slice;
      end else begin
         req_valid <= 0;
      end
      taken <= 0;
   end

   // receiver
   always @(negedge clock) begin
      if (idle_mode == 2 && !held_once && pending_reqs.size() > sqg_pkg::PIPE_LAT + 8) begin
         held_once <= 1;
         hold_left <= 300;
         rsp_ready <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= $urandom_range(99) >= (idle_mode == 0 ? 55 : idle_mode == 1 ? 26 : 0);
      end
   end

   // monitor
   always @(posedge clock) begin
      sqg_pkg::quad_type got, want;
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("end of test: mismatches");
         $finish;
      end
      if (!reset && req_valid && req_ready) begin
         expected_quads.insert(expected_quads.size(), quad_corners(pending_reqs[0]));
         void'(pending_reqs.pop_front());
         taken <= 1;
         accepted <= accepted + 1;
         if (accepted == 400) idle_mode <= 1;
         if (accepted == 800) idle_mode <= 2;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{'{rsp_v0_x, rsp_v0_y, rsp_v0_z}, '{rsp_v1_x, rsp_v1_y, rsp_v1_z},
                 '{rsp_v2_x, rsp_v2_y, rsp_v2_z}, '{rsp_v3_x, rsp_v3_y, rsp_v3_z}};
         if (expected_quads.size() == 0) begin
            errors = errors + 1;
            $display("%0t: unexpected item %h", $time, got);
         end else begin
            want = expected_quads.pop_front();
            for (int f = 0; f < 12; f++)
               if (got[383 - 32 * f -: 32] !== want[383 - 32 * f -: 32]) begin
                  errors = errors + 1;
                  $display("%0t: field %0d expected %h actual %h", $time, f,
                           want[383 - 32 * f -: 32], got[383 - 32 * f -: 32]);
               end
         end
      end
   end

   initial begin
      repeat (2) @(negedge clock);
      reset <= 0;
      set_sphere(32'h0, 32'h0, 32'h0, 32'd65536, 32'd16);
      queue_quad(0, 0); queue_quad(7, 3); queue_quad(8, 3); queue_quad(15, 15);
      queue_quad(16, 0); queue_quad(1023, 1023); queue_quad(0, 1023); queue_quad(1023, 0);
      queue_quad(682, 341); queue_quad(341, 682); queue_quad(4, 8); queue_quad(12, 12);
      drain();
      set_sphere(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFB_0000, 32'h7FFF_FFFF, 32'd1024);
      queue_quad(0, 0); queue_quad(511, 1023); queue_quad(512, 512); queue_quad(1023, 1023);
      queue_random(60);
      drain();
      set_sphere(32'h0001_0000, 32'hFFFF_0000, 32'h0, 32'h0, 32'd0);
      queue_quad(0, 0); queue_quad(1, 1); queue_random(20);
      drain();
      set_sphere(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'd2047);
      queue_random(60);
      drain();
      for (int ph = 0; ph < 12; ph++) begin
         logic [31:0] segs;
         case ($urandom_range(4))
            0: segs = $urandom_range(1, 3);
            1: segs = $urandom_range(4, 64);
            2: segs = $urandom_range(2047);
            default: segs = $urandom_range(4, 32);
         endcase
         if (ph % 2 == 0)
            set_sphere($urandom, $urandom, $urandom, $urandom, segs);
         else
            set_sphere($urandom_range(65535) << 8, -($urandom_range(65535) << 8),
                       $urandom_range(255) << 12, $urandom_range(1 << 22), segs);
         queue_random(85);
         drain();
      end
      if (errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

`default_nettype wire
